// ===== rtl/core/tpss_pkg.sv =====
package tpss_pkg;

	localparam int AXES        = 3;
	localparam int DIV_LANES   = 2;
	localparam int AX_RADIAL   = 0;
	localparam int AX_ANGULAR  = 1;
	localparam int AX_EXTRUDER = 2;

	localparam int DELAY_BITS  = 16;
	localparam int RADIUS_BITS = 12;
	localparam int SLOPE_BITS  = 8;
	localparam int CUT_BITS    = SLOPE_BITS + RADIUS_BITS;
	localparam int POS_BITS    = 32;
	localparam int DATA_BITS   = 32;

	localparam int NUM_REGS    = 5;
	localparam int ADDR_BITS   = 5;
	localparam int IDX_BITS    = ADDR_BITS - 2;

	localparam logic [IDX_BITS-1:0] REG_EXTRUDER_BASE_DELAY = IDX_BITS'(0);
	localparam logic [IDX_BITS-1:0] REG_RADIUS_THRESHOLD_Q  = IDX_BITS'(1);
	localparam logic [IDX_BITS-1:0] REG_RADIUS_SLOPE        = IDX_BITS'(2);
	localparam logic [IDX_BITS-1:0] REG_IDLE_RADIAL_DELAY   = IDX_BITS'(3);
	localparam logic [IDX_BITS-1:0] REG_IDLE_ANGULAR_DELAY  = IDX_BITS'(4);

	localparam logic [DELAY_BITS-1:0]  RST_EXTRUDER_BASE_DELAY = 16'd12000;
	localparam logic [RADIUS_BITS-1:0] RST_RADIUS_THRESHOLD_Q  = 12'd80;
	localparam logic [SLOPE_BITS-1:0]  RST_RADIUS_SLOPE        = 8'd30;
	localparam logic [DELAY_BITS-1:0]  RST_IDLE_RADIAL_DELAY   = 16'd750;
	localparam logic [DELAY_BITS-1:0]  RST_IDLE_ANGULAR_DELAY  = 16'd500;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic [DELAY_BITS-1:0]  extruder_base_delay;
		logic [RADIUS_BITS-1:0] radius_threshold_q;
		logic [SLOPE_BITS-1:0]  radius_slope;
		logic [DELAY_BITS-1:0]  idle_radial_delay;
		logic [DELAY_BITS-1:0]  idle_angular_delay;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic setup;
		logic mul;
		logic div_step;
		logic load_fin;
		logic tick_step;
		logic tick_fin;
	} cmd_t;

	typedef struct packed {
		logic kind_tick;
		logic ext_zero;
	} stat_t;

	typedef struct packed {
		logic                radial_step;
		logic                angular_step;
		logic                extruder_step;
		logic                radial_dir;
		logic                angular_dir;
		logic                extruder_dir;
		logic                busy_res;
		logic                move_done;
		logic [POS_BITS-1:0] angular_position;
	} res_t;

endpackage

// ===== rtl/core/tpss_if.sv =====
interface tpss_req_if import tpss_pkg::*; #(parameter int GOAL_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic signed [GOAL_BITS-1:0]   goal_radial;
	logic signed [GOAL_BITS-1:0]   goal_angular;
	logic signed [GOAL_BITS-1:0]   goal_extruder;
	logic        [RADIUS_BITS-1:0] radius_q;

	modport source (output valid, kind, goal_radial, goal_angular, goal_extruder, radius_q,
		input ready);
	modport sink (input valid, kind, goal_radial, goal_angular, goal_extruder, radius_q,
		output ready);
endinterface

interface tpss_rsp_if import tpss_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic                       radial_step;
	logic                       angular_step;
	logic                       extruder_step;
	logic                       radial_dir;
	logic                       angular_dir;
	logic                       extruder_dir;
	logic                       busy_res;
	logic                       move_done;
	logic signed [POS_BITS-1:0] angular_position;

	modport source (output valid, radial_step, angular_step, extruder_step, radial_dir,
		angular_dir, extruder_dir, busy_res, move_done, angular_position, input ready);
	modport sink (input valid, radial_step, angular_step, extruder_step, radial_dir,
		angular_dir, extruder_dir, busy_res, move_done, angular_position, output ready);
endinterface

// ===== rtl/core/three_axis_step_pulse_scheduler_unit.sv =====
// Step pulse scheduler for a radial, an angular and an extruder axis.
// req carries one item per valid/ready handshake: kind 0 loads a move (signed
// goals and the radius in Q8.4), kind 1 is a one-microsecond tick.
// rsp returns one item per request: pin levels, directions, busy, move_done
// and the angular position. Registers are written over the APB port.
// Sequencing: a tick goes from decode to tick finish, which raises rsp valid.
// A load with a nonzero extruder goal goes through decode, multiply and the
// bit-serial divider that works out the radial and angular intervals in
// two parallel lanes, one quotient bit per cycle, to load finish; a load with
// a zero extruder goal goes from decode to load finish. One item is in flight
// at a time; the next request can be taken on the edge the rsp item leaves.
// A request is taken only while the block is idle and no rsp item waits, or
// the waiting one leaves on the same edge; while rsp is stalled the finished
// item is held and no request is taken.
// Reset clears pins, directions, goals and the angular position and loads
// the register defaults.
module three_axis_step_pulse_scheduler_unit import tpss_pkg::*; #(
	parameter int GOAL_BITS = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	tpss_req_if.sink             req,
	tpss_rsp_if.source           rsp
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;
	res_t  res;

	tpss_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tpss_ctrl #(
		.TIME_BITS (TIME_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tpss_dp #(
		.GOAL_BITS (GOAL_BITS),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg           (cfg),
		.kind          (req.kind),
		.goal_radial   (req.goal_radial),
		.goal_angular  (req.goal_angular),
		.goal_extruder (req.goal_extruder),
		.radius_q      (req.radius_q),
		.stat          (stat),
		.res           (res)
	);

	assign rsp.radial_step      = res.radial_step;
	assign rsp.angular_step     = res.angular_step;
	assign rsp.extruder_step    = res.extruder_step;
	assign rsp.radial_dir       = res.radial_dir;
	assign rsp.angular_dir      = res.angular_dir;
	assign rsp.extruder_dir     = res.extruder_dir;
	assign rsp.busy_res         = res.busy_res;
	assign rsp.move_done        = res.move_done;
	assign rsp.angular_position = res.angular_position;

endmodule

// ===== rtl/core/tpss_regs.sv =====
module tpss_regs import tpss_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	cfg_t                cfg_q;
	logic [IDX_BITS-1:0] idx;
	logic                wr_en;

	assign idx    = paddr[ADDR_BITS-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.extruder_base_delay <= RST_EXTRUDER_BASE_DELAY;
			cfg_q.radius_threshold_q  <= RST_RADIUS_THRESHOLD_Q;
			cfg_q.radius_slope        <= RST_RADIUS_SLOPE;
			cfg_q.idle_radial_delay   <= RST_IDLE_RADIAL_DELAY;
			cfg_q.idle_angular_delay  <= RST_IDLE_ANGULAR_DELAY;
		end else if (wr_en) begin
			unique case (idx)
				REG_EXTRUDER_BASE_DELAY: cfg_q.extruder_base_delay <= pwdata[DELAY_BITS-1:0];
				REG_RADIUS_THRESHOLD_Q:  cfg_q.radius_threshold_q  <= pwdata[RADIUS_BITS-1:0];
				REG_RADIUS_SLOPE:        cfg_q.radius_slope        <= pwdata[SLOPE_BITS-1:0];
				REG_IDLE_RADIAL_DELAY:   cfg_q.idle_radial_delay   <= pwdata[DELAY_BITS-1:0];
				REG_IDLE_ANGULAR_DELAY:  cfg_q.idle_angular_delay  <= pwdata[DELAY_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_EXTRUDER_BASE_DELAY: prdata = DATA_BITS'(cfg_q.extruder_base_delay);
			REG_RADIUS_THRESHOLD_Q:  prdata = DATA_BITS'(cfg_q.radius_threshold_q);
			REG_RADIUS_SLOPE:        prdata = DATA_BITS'(cfg_q.radius_slope);
			REG_IDLE_RADIAL_DELAY:   prdata = DATA_BITS'(cfg_q.idle_radial_delay);
			REG_IDLE_ANGULAR_DELAY:  prdata = DATA_BITS'(cfg_q.idle_angular_delay);
			default:                 prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/tpss_ctrl.sv =====
module tpss_ctrl import tpss_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam int CNT_BITS = $clog2(TIME_BITS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_LD_MUL,
		S_LD_DIV,
		S_LD_FIN,
		S_TICK_FIN
	} state_t;

	state_t              state_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                out_valid_q;
	logic                accept;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:     cmd.accept = accept;
			S_DECODE: begin
				if (stat.kind_tick) begin
					cmd.tick_step = 1'b1;
				end else begin
					cmd.setup = 1'b1;
				end
			end
			S_LD_MUL:   cmd.mul = 1'b1;
			S_LD_DIV:   cmd.div_step = 1'b1;
			S_LD_FIN:   cmd.load_fin = 1'b1;
			S_TICK_FIN: cmd.tick_fin = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (stat.kind_tick) begin
						state_q <= S_TICK_FIN;
					end else if (stat.ext_zero) begin
						state_q <= S_LD_FIN;
					end else begin
						state_q <= S_LD_MUL;
					end
				end
				S_LD_MUL: begin
					cnt_q   <= CNT_BITS'(TIME_BITS - 1);
					state_q <= S_LD_DIV;
				end
				S_LD_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_LD_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_LD_FIN, S_TICK_FIN: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_fin_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_fin || cmd.tick_fin) |-> !out_valid_q)
		else $error("result written while previous item still pending");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LD_DIV && cnt_q == '0) |=> state_q == S_LD_FIN)
		else $error("divider did not hand over to load finish");

	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_LD_FIN || state_q == S_TICK_FIN))
		else $error("result valid raised outside a finish state");

endmodule

// ===== rtl/core/tpss_dp.sv =====
module tpss_dp import tpss_pkg::*; #(
	parameter int GOAL_BITS = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	input  cfg_t                   cfg,
	input  logic                   kind,
	input  logic [GOAL_BITS-1:0]   goal_radial,
	input  logic [GOAL_BITS-1:0]   goal_angular,
	input  logic [GOAL_BITS-1:0]   goal_extruder,
	input  logic [RADIUS_BITS-1:0] radius_q,
	output stat_t                  stat,
	output res_t                   res
);

	localparam int PROD_BITS = DELAY_BITS + GOAL_BITS;

	function automatic logic [GOAL_BITS-1:0] magnitude(input logic [GOAL_BITS-1:0] v);
		magnitude = v[GOAL_BITS-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic positive(input logic [GOAL_BITS-1:0] v);
		positive = !v[GOAL_BITS-1] && (v != '0);
	endfunction

	// captured item
	logic                   kind_q;
	logic [GOAL_BITS-1:0]   goal_in_q [AXES];
	logic [RADIUS_BITS-1:0] radius_in_q;

	// move state
	logic [GOAL_BITS-1:0]   goal_q     [AXES];
	logic [GOAL_BITS-1:0]   done_q     [AXES];
	logic [TIME_BITS-1:0]   interval_q [AXES];
	logic [TIME_BITS-1:0]   due_q      [AXES];
	logic [GOAL_BITS-1:0]   acc_q      [AXES];
	logic [GOAL_BITS-1:0]   rem_step_q [AXES];
	logic [TIME_BITS-1:0]   elapsed_q;
	logic [AXES-1:0]        pin_q;
	logic [AXES-1:0]        dir_q;
	logic                   move_active_q;
	logic [POS_BITS-1:0]    angular_q;
	logic [DELAY_BITS-1:0]  d_q;
	res_t                   res_q;

	// serial divider lanes
	logic [TIME_BITS-1:0]   quo_q   [DIV_LANES];
	logic [GOAL_BITS-1:0]   rem_q   [DIV_LANES];
	logic [GOAL_BITS:0]     trial   [DIV_LANES];
	logic [GOAL_BITS:0]     trial_d [DIV_LANES];
	logic                   trial_ge[DIV_LANES];
	logic [DELAY_BITS-1:0]  idle_dly[DIV_LANES];

	logic [GOAL_BITS-1:0]   mag     [AXES];
	logic [CUT_BITS-1:0]    full;
	logic [CUT_BITS-1:0]    cut;
	logic [CUT_BITS-1:0]    cut_diff;
	logic [DELAY_BITS-1:0]  d_next;
	logic [PROD_BITS-1:0]   prod;
	logic [PROD_BITS+TIME_BITS-1:0] prod_ext;

	logic [AXES-1:0]        fire;
	logic [AXES-1:0]        carry;
	logic [AXES-1:0]        pend;
	logic [GOAL_BITS:0]     acc_sum [AXES];
	logic [GOAL_BITS:0]     acc_sub [AXES];
	logic [GOAL_BITS-1:0]   acc_nx  [AXES];
	logic [TIME_BITS-1:0]   due_nx  [AXES];
	logic                   time_top;
	logic                   any_pend;
	logic                   complete;
	logic [POS_BITS-1:0]    ang_add;
	res_t                   res_nx;

	assign stat.kind_tick = (kind_q == KIND_TICK);
	assign stat.ext_zero  = (goal_in_q[AX_EXTRUDER] == '0);
	assign res            = res_q;

	// load setup: magnitudes and radius-corrected extruder delay
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			mag[i] = magnitude(goal_in_q[i]);
		end
		full     = {cfg.extruder_base_delay, 4'b0000};
		cut      = CUT_BITS'(cfg.radius_slope) * CUT_BITS'(radius_in_q);
		cut_diff = full - cut;
		if (radius_in_q > cfg.radius_threshold_q) begin
			d_next = (full > cut) ? cut_diff[CUT_BITS-1:4] : '0;
		end else begin
			d_next = cfg.extruder_base_delay;
		end
	end

	assign prod     = PROD_BITS'(d_q) * PROD_BITS'(goal_q[AX_EXTRUDER]);
	assign prod_ext = {{TIME_BITS{1'b0}}, prod};

	assign idle_dly[AX_RADIAL]  = cfg.idle_radial_delay;
	assign idle_dly[AX_ANGULAR] = cfg.idle_angular_delay;

	always_comb begin
		for (int l = 0; l < DIV_LANES; l++) begin
			trial[l]    = {rem_q[l], quo_q[l][TIME_BITS-1]};
			trial_ge[l] = trial[l] >= {1'b0, goal_q[l]};
			trial_d[l]  = trial[l] - {1'b0, goal_q[l]};
		end
	end

	// tick: elapsed+1 > due, written without the increment
	assign time_top = (elapsed_q == {TIME_BITS{1'b1}});

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			pend[i]    = done_q[i] < goal_q[i];
			fire[i]    = move_active_q && pend[i] && !time_top && (elapsed_q >= due_q[i]);
			acc_sum[i] = {1'b0, acc_q[i]} + {1'b0, rem_step_q[i]};
			carry[i]   = (goal_q[i] != '0) && (acc_sum[i] >= {1'b0, goal_q[i]});
			acc_sub[i] = acc_sum[i] - {1'b0, goal_q[i]};
			acc_nx[i]  = carry[i] ? acc_sub[i][GOAL_BITS-1:0] : acc_sum[i][GOAL_BITS-1:0];
			due_nx[i]  = due_q[i] + interval_q[i] + TIME_BITS'(carry[i]);
		end
	end

	assign any_pend = |pend;
	assign complete = move_active_q && !any_pend;
	assign ang_add  = angular_q + POS_BITS'(done_q[AX_ANGULAR] >> 1);

	always_comb begin
		res_nx.radial_step      = pin_q[AX_RADIAL];
		res_nx.angular_step     = pin_q[AX_ANGULAR];
		res_nx.extruder_step    = pin_q[AX_EXTRUDER];
		res_nx.radial_dir       = dir_q[AX_RADIAL];
		res_nx.angular_dir      = dir_q[AX_ANGULAR];
		res_nx.extruder_dir     = dir_q[AX_EXTRUDER];
		res_nx.busy_res         = any_pend;
		res_nx.move_done        = cmd.tick_fin && complete;
		res_nx.angular_position = (cmd.tick_fin && complete) ? ang_add : angular_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				goal_q[i] <= '0;
				done_q[i] <= '0;
			end
			pin_q         <= '0;
			dir_q         <= '0;
			move_active_q <= 1'b0;
			angular_q     <= '0;
		end else begin
			if (cmd.setup) begin
				for (int i = 0; i < AXES; i++) begin
					goal_q[i] <= mag[i];
					done_q[i] <= '0;
				end
				dir_q <= {1'b1, positive(goal_in_q[AX_ANGULAR]), positive(goal_in_q[AX_RADIAL])};
			end
			if (cmd.tick_step) begin
				pin_q <= pin_q ^ fire;
				for (int i = 0; i < AXES; i++) begin
					if (fire[i]) begin
						done_q[i] <= done_q[i] + 1'b1;
					end
				end
			end
			if (cmd.load_fin) begin
				move_active_q <= 1'b1;
			end
			if (cmd.tick_fin && complete) begin
				angular_q     <= ang_add;
				move_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q                 <= kind;
			goal_in_q[AX_RADIAL]   <= goal_radial;
			goal_in_q[AX_ANGULAR]  <= goal_angular;
			goal_in_q[AX_EXTRUDER] <= goal_extruder;
			radius_in_q            <= radius_q;
		end
		if (cmd.setup) begin
			d_q <= d_next;
		end
		if (cmd.mul) begin
			for (int l = 0; l < DIV_LANES; l++) begin
				quo_q[l] <= prod_ext[TIME_BITS-1:0];
				rem_q[l] <= '0;
			end
		end
		if (cmd.div_step) begin
			for (int l = 0; l < DIV_LANES; l++) begin
				quo_q[l] <= {quo_q[l][TIME_BITS-2:0], trial_ge[l]};
				rem_q[l] <= trial_ge[l] ? trial_d[l][GOAL_BITS-1:0] : trial[l][GOAL_BITS-1:0];
			end
		end
		if (cmd.load_fin) begin
			for (int l = 0; l < DIV_LANES; l++) begin
				if (stat.ext_zero) begin
					interval_q[l] <= TIME_BITS'(idle_dly[l]);
					rem_step_q[l] <= '0;
				end else if (goal_q[l] != '0) begin
					interval_q[l] <= quo_q[l];
					rem_step_q[l] <= rem_q[l];
				end else begin
					interval_q[l] <= '0;
					rem_step_q[l] <= '0;
				end
			end
			interval_q[AX_EXTRUDER] <= stat.ext_zero ? '0 : TIME_BITS'(d_q);
			rem_step_q[AX_EXTRUDER] <= '0;
			for (int i = 0; i < AXES; i++) begin
				due_q[i] <= '0;
				acc_q[i] <= '0;
			end
			elapsed_q <= '0;
		end
		if (cmd.tick_step && move_active_q) begin
			elapsed_q <= elapsed_q + 1'b1;
			for (int i = 0; i < AXES; i++) begin
				if (fire[i]) begin
					due_q[i] <= due_nx[i];
					acc_q[i] <= acc_nx[i];
				end
			end
		end
		if (cmd.load_fin || cmd.tick_fin) begin
			res_q <= res_nx;
		end
	end

	a_done_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q[AX_RADIAL] <= goal_q[AX_RADIAL] && done_q[AX_ANGULAR] <= goal_q[AX_ANGULAR]
			&& done_q[AX_EXTRUDER] <= goal_q[AX_EXTRUDER])
		else $error("toggle count passed its goal");

	a_move_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(move_active_q) |-> $past(cmd.tick_fin))
		else $error("move ended outside a tick finish");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
	import tpss_pkg::*;

	localparam int GOAL_W = 16;
	localparam int RUN_CAP = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1800;
	localparam int NPHASE = 8;

	typedef enum logic [1:0] {OP_LOAD, OP_TICK, OP_RUN, OP_CFG} row_op_t;

	typedef struct {
		row_op_t                   op;
		logic signed [GOAL_W-1:0]  gr;
		logic signed [GOAL_W-1:0]  ga;
		logic signed [GOAL_W-1:0]  ge;
		logic [RADIUS_BITS-1:0]    rq;
		logic [IDX_BITS-1:0]       idx;
		logic [DATA_BITS-1:0]      wdata;
		bit                        typed;
		res_t                      want;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	tpss_req_if #(.GOAL_BITS(GOAL_W)) req_ch ();
	tpss_rsp_if rsp_ch ();

	three_axis_step_pulse_scheduler_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// schedule model state
	cfg_t regs_shadow = '{RST_EXTRUDER_BASE_DELAY, RST_RADIUS_THRESHOLD_Q, RST_RADIUS_SLOPE,
		RST_IDLE_RADIAL_DELAY, RST_IDLE_ANGULAR_DELAY};
	logic [GOAL_W-1:0] tgt [AXES] = '{default: '0};
	logic [GOAL_W-1:0] done_n [AXES] = '{default: '0};
	logic [31:0] step_gap [AXES] = '{default: '0};
	logic [31:0] next_due [AXES] = '{default: '0};
	logic [31:0] carry_acc [AXES] = '{default: '0};
	logic [31:0] carry_inc [AXES] = '{default: '0};
	logic [31:0] clock_us = '0;
	logic [31:0] ang_total = '0;
	logic [2:0]  pins = '0;
	logic [2:0]  dirs = '0;
	bit          running = 0;

	res_t pending_status [$];
	int   mismatches = 0;
	int   items_sent = 0;
	int   quiet_cycles = 0;
	int   gap_rate = 0;
	int   stall_rate = 0;
	bit   calm = 0;

	// want = {pins rad/ang/ext, dirs rad/ang/ext, busy, done, angular position}
	plan_row_t opening_plan [22] = '{
		'{OP_TICK, 0, 0, 0, 0, '0, 0, 1, {3'b000, 3'b000, 1'b0, 1'b0, 32'd0}},
		'{OP_LOAD, 0, 0, 0, 0, '0, 0, 1, {3'b000, 3'b001, 1'b0, 1'b0, 32'd0}},
		'{OP_TICK, 0, 0, 0, 0, '0, 0, 1, {3'b000, 3'b001, 1'b0, 1'b1, 32'd0}},
		'{OP_TICK, 0, 0, 0, 0, '0, 0, 1, {3'b000, 3'b001, 1'b0, 1'b0, 32'd0}},
		'{OP_LOAD, 2, -4, 0, 0, '0, 0, 1, {3'b000, 3'b101, 1'b1, 1'b0, 32'd0}},
		'{OP_TICK, 0, 0, 0, 0, '0, 0, 0, '0},
		'{OP_LOAD, 32767, -32768, -32768, 4095, '0, 0, 1,
			{3'b110, 3'b101, 1'b1, 1'b0, 32'd0}},
		'{OP_TICK, 0, 0, 0, 0, '0, 0, 1, {3'b001, 3'b101, 1'b1, 1'b0, 32'd0}},
		'{OP_LOAD, -32768, 32767, 1, 0, '0, 0, 1, {3'b001, 3'b011, 1'b1, 1'b0, 32'd0}},
		'{OP_TICK, 0, 0, 0, 0, '0, 0, 0, '0},
		'{OP_CFG, 0, 0, 0, 0, REG_EXTRUDER_BASE_DELAY, 3, 0, '0},
		'{OP_CFG, 0, 0, 0, 0, REG_RADIUS_SLOPE, 255, 0, '0},
		'{OP_CFG, 0, 0, 0, 0, REG_RADIUS_THRESHOLD_Q, 0, 0, '0},
		// corrected delay goes negative and clamps, so every interval is zero
		'{OP_LOAD, 5, 3, -2, 4095, '0, 0, 0, '0},
		'{OP_RUN, 0, 0, 0, 0, '0, 0, 0, '0},
		'{OP_CFG, 0, 0, 0, 0, REG_RADIUS_SLOPE, 1, 0, '0},
		// K = 8 over goals 7 and 3: remainder carry spreads the slip
		'{OP_LOAD, 7, -3, 4, 16, '0, 0, 0, '0},
		'{OP_RUN, 0, 0, 0, 0, '0, 0, 0, '0},
		'{OP_CFG, 0, 0, 0, 0, REG_IDLE_RADIAL_DELAY, 2, 0, '0},
		'{OP_CFG, 0, 0, 0, 0, REG_IDLE_ANGULAR_DELAY, 3, 0, '0},
		'{OP_LOAD, -3, 5, 0, 100, '0, 0, 0, '0},
		'{OP_RUN, 0, 0, 0, 0, '0, 0, 0, '0}
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [GOAL_W-1:0] magnitude(logic signed [GOAL_W-1:0] g);
		return g[GOAL_W-1] ? GOAL_W'(-g) : g;
	endfunction

	function automatic bit outstanding();
		for (int i = 0; i < AXES; i++)
			if (done_n[i] < tgt[i])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic res_t advance_schedule(logic kind, logic signed [GOAL_W-1:0] gr,
		logic signed [GOAL_W-1:0] ga, logic signed [GOAL_W-1:0] ge,
		logic [RADIUS_BITS-1:0] rq);
		logic [31:0] d;
		logic [31:0] k;
		logic [31:0] full;
		logic [31:0] cut;
		logic [31:0] nd;
		bit fin;
		fin = 1'b0;
		if (kind == KIND_LOAD) begin
			tgt[AX_RADIAL] = magnitude(gr);
			tgt[AX_ANGULAR] = magnitude(ga);
			tgt[AX_EXTRUDER] = magnitude(ge);
			dirs = {1'b1, (ga != 0 && !ga[GOAL_W-1]), (gr != 0 && !gr[GOAL_W-1])};
			for (int i = 0; i < AXES; i++) begin
				carry_acc[i] = '0;
				carry_inc[i] = '0;
				next_due[i] = '0;
				done_n[i] = '0;
			end
			if (tgt[AX_EXTRUDER] != 0) begin
				d = 32'(regs_shadow.extruder_base_delay);
				if (rq > regs_shadow.radius_threshold_q) begin
					full = d * 32'd16;
					cut = 32'(regs_shadow.radius_slope) * 32'(rq);
					d = (full > cut) ? ((full - cut) >> 4) : 32'd0;
				end
				k = d * 32'(tgt[AX_EXTRUDER]);
				for (int i = 0; i < 2; i++) begin
					if (tgt[i] != 0) begin
						step_gap[i] = k / tgt[i];
						carry_inc[i] = k % tgt[i];
					end else begin
						step_gap[i] = '0;
					end
				end
				step_gap[AX_EXTRUDER] = d;
			end else begin
				step_gap[AX_RADIAL] = 32'(regs_shadow.idle_radial_delay);
				step_gap[AX_ANGULAR] = 32'(regs_shadow.idle_angular_delay);
				step_gap[AX_EXTRUDER] = '0;
			end
			clock_us = '0;
			running = 1'b1;
		end else if (running) begin
			clock_us = clock_us + 32'd1;
			for (int i = 0; i < AXES; i++) begin
				if (done_n[i] < tgt[i] && clock_us > next_due[i]) begin
					pins[i] = ~pins[i];
					nd = next_due[i] + step_gap[i];
					carry_acc[i] = carry_acc[i] + carry_inc[i];
					if (tgt[i] != 0 && carry_acc[i] >= 32'(tgt[i])) begin
						carry_acc[i] = carry_acc[i] - 32'(tgt[i]);
						nd = nd + 32'd1;
					end
					next_due[i] = nd;
					done_n[i] = done_n[i] + 1'b1;
				end
			end
			if (!outstanding()) begin
				ang_total = ang_total + 32'(done_n[AX_ANGULAR] >> 1);
				running = 1'b0;
				fin = 1'b1;
			end
		end
		return {pins[0], pins[1], pins[2], dirs[0], dirs[1], dirs[2], outstanding(), fin,
			ang_total};
	endfunction

	function automatic logic signed [GOAL_W-1:0] small_goal();
		return GOAL_W'(int'($urandom_range(0, 18)) - 9);
	endfunction

	task automatic send_item(input logic kind, input logic signed [GOAL_W-1:0] gr,
		input logic signed [GOAL_W-1:0] ga, input logic signed [GOAL_W-1:0] ge,
		input logic [RADIUS_BITS-1:0] rq, input bit typed = 1'b0, input res_t want = '0);
		res_t model;
		@(negedge clk);
		if (!calm && gap_rate != 0 && $urandom_range(0, gap_rate) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.goal_radial <= gr;
		req_ch.goal_angular <= ga;
		req_ch.goal_extruder <= ge;
		req_ch.radius_q <= rq;
		do @(posedge clk); while (!req_ch.ready);
		if (kind == KIND_LOAD || running)
			items_sent++;
		model = advance_schedule(kind, gr, ga, ge, rq);
		pending_status.push_back(typed ? want : model);
	endtask

	task automatic run_move(input int cap);
		int n;
		n = 0;
		while (running && n < cap) begin
			send_item(KIND_TICK, '0, '0, '0, '0);
			n++;
		end
	endtask

	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [DATA_BITS-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_EXTRUDER_BASE_DELAY: regs_shadow.extruder_base_delay = value[DELAY_BITS-1:0];
			REG_RADIUS_THRESHOLD_Q: regs_shadow.radius_threshold_q = value[RADIUS_BITS-1:0];
			REG_RADIUS_SLOPE: regs_shadow.radius_slope = value[SLOPE_BITS-1:0];
			REG_IDLE_RADIAL_DELAY: regs_shadow.idle_radial_delay = value[DELAY_BITS-1:0];
			REG_IDLE_ANGULAR_DELAY: regs_shadow.idle_angular_delay = value[DELAY_BITS-1:0];
			default: ;
		endcase
	endtask

	// response side backpressure
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && stall_rate != 0 && $urandom_range(0, stall_rate) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = {rsp_ch.radial_step, rsp_ch.angular_step, rsp_ch.extruder_step,
				rsp_ch.radial_dir, rsp_ch.angular_dir, rsp_ch.extruder_dir,
				rsp_ch.busy_res, rsp_ch.move_done, rsp_ch.angular_position};
			if (pending_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: pins %b%b%b pos %0d", got.radial_step,
						got.angular_step, got.extruder_step, $signed(got.angular_position));
			end else begin
				want = pending_status.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: pins %b%b%b/%b%b%b dirs %b%b%b/%b%b%b ",
							"busy %b/%b done %b/%b pos %0d/%0d (exp/act)"},
							want.radial_step, want.angular_step, want.extruder_step,
							got.radial_step, got.angular_step, got.extruder_step,
							want.radial_dir, want.angular_dir, want.extruder_dir,
							got.radial_dir, got.angular_dir, got.extruder_dir,
							want.busy_res, got.busy_res, want.move_done, got.move_done,
							$signed(want.angular_position), $signed(got.angular_position));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
			|| (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int rand_base;
		int roll;
		logic [DATA_BITS-1:0] v_ebase;
		logic [DATA_BITS-1:0] v_thr;
		logic [DATA_BITS-1:0] v_slope;
		logic [DATA_BITS-1:0] v_idle_r;
		logic [DATA_BITS-1:0] v_idle_a;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_LOAD;
		req_ch.goal_radial = '0;
		req_ch.goal_angular = '0;
		req_ch.goal_extruder = '0;
		req_ch.radius_q = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		foreach (opening_plan[r]) begin
			case (opening_plan[r].op)
				OP_LOAD, OP_TICK:
					send_item((opening_plan[r].op == OP_TICK) ? KIND_TICK : KIND_LOAD,
						opening_plan[r].gr, opening_plan[r].ga, opening_plan[r].ge,
						opening_plan[r].rq, opening_plan[r].typed, opening_plan[r].want);
				OP_RUN: run_move(RUN_CAP);
				OP_CFG: begin
					settle();
					write_reg(opening_plan[r].idx, opening_plan[r].wdata);
				end
				default: ;
			endcase
		end

		rand_base = items_sent;
		for (int ph = 0; ph < NPHASE; ph++) begin
			settle();
			case (ph)
				0: begin
					v_ebase = 0; v_thr = 0; v_slope = 0; v_idle_r = 0; v_idle_a = 0;
				end
				1: begin
					v_ebase = 65535; v_thr = 4095; v_slope = 255;
					v_idle_r = 65535; v_idle_a = 65535;
				end
				default: begin
					v_ebase = $urandom_range(0, 16);
					v_thr = $urandom_range(0, 1) ? $urandom_range(0, 48) : $urandom_range(0, 4095);
					v_slope = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255);
					v_idle_r = $urandom_range(0, 8);
					v_idle_a = $urandom_range(0, 8);
				end
			endcase
			write_reg(REG_EXTRUDER_BASE_DELAY, v_ebase);
			write_reg(REG_RADIUS_THRESHOLD_Q, v_thr);
			write_reg(REG_RADIUS_SLOPE, v_slope);
			write_reg(REG_IDLE_RADIAL_DELAY, v_idle_r);
			write_reg(REG_IDLE_ANGULAR_DELAY, v_idle_a);
			gap_rate = $urandom_range(0, 2) * 4;
			stall_rate = $urandom_range(0, 2) * 4;
			calm = (ph == NPHASE - 1);

			while (items_sent - rand_base < (ph + 1) * RANDOM_ITEMS / NPHASE) begin
				roll = $urandom_range(0, 15);
				if (roll < 11 && ph != 1) begin
					send_item(KIND_LOAD, small_goal(), small_goal(), small_goal(),
						RADIUS_BITS'($urandom_range(0, 1) ? $urandom_range(0, 63)
							: $urandom_range(0, 4095)));
					if ($urandom_range(0, 7) == 0)
						run_move($urandom_range(1, 5));
					else
						run_move(RUN_CAP);
				end else if (roll < 14) begin
					send_item(KIND_LOAD, GOAL_W'($urandom), GOAL_W'($urandom), GOAL_W'($urandom),
						RADIUS_BITS'($urandom));
					repeat ($urandom_range(1, 4)) send_item(KIND_TICK, '0, '0, '0, '0);
				end else if (roll < 15) begin
					repeat ($urandom_range(1, 3)) send_item(KIND_TICK, '0, '0, '0, '0);
				end else begin
					settle();
				end
			end
		end

		settle();
		if (mismatches == 0 && pending_status.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
